@@ rtl/twa_pkg.sv @@
// shared constants, types and weight function for the triangular window average
package twa_pkg;

    localparam int TAPS        = 32;
    localparam int SAMPLE_BITS = 20;

    localparam int SLOT_BITS  = $clog2(TAPS);
    localparam int HALF_TAPS  = TAPS / 2;
    localparam int WT_BITS    = SLOT_BITS + 1;
    localparam int PROD_BITS  = SAMPLE_BITS + WT_BITS + 1;
    localparam int ACC_BITS   = SAMPLE_BITS + 2 * SLOT_BITS;
    localparam int SHIFT      = 2 * SLOT_BITS - 1;
    localparam int ROUND_HALF = 1 << (SHIFT - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [SLOT_BITS-1:0]          t_slot;
    typedef logic [WT_BITS-1:0]            t_weight;

    typedef struct packed {
        logic  load;
        logic  rd_en;
        t_slot age;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // odd weights rising from the oldest sample to the middle and falling to the newest
    function automatic t_weight tap_weight(input t_slot age);
        t_weight w;
        if (age < SLOT_BITS'(HALF_TAPS)) begin
            w = {age, 1'b1};
        end else begin
            w = WT_BITS'(2 * TAPS - 1) - {age, 1'b0};
        end
        return w;
    endfunction

endpackage

@@ rtl/twa_ram.sv @@
// generic single write port ram with registered read
module twa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/twa_ctrl.sv @@
// sequencing state machine for the triangular window average
module twa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  twa_pkg::t_sts i_sts,
    output twa_pkg::t_cmd o_cmd
);
    import twa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_slot  r_cnt, n_cnt;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    o_cmd.age   = '0;
                    n_cnt       = SLOT_BITS'(1);
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.age   = r_cnt;
                if (r_cnt == SLOT_BITS'(TAPS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ rtl/twa_dp.sv @@
// ring buffer, weighted accumulator and output register
module twa_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  twa_pkg::t_cmd    i_cmd,
    output twa_pkg::t_sts    o_sts,
    input  twa_pkg::t_sample i_sample,
    input  logic             i_stall,
    output logic             o_valid,
    output twa_pkg::t_sample o_smoothed
);
    import twa_pkg::*;

    t_slot   r_slot;
    logic    r_full;
    logic    r_primed;
    t_sample r_prime_val;
    logic    r_mac;
    logic    r_use_ram;
    t_weight r_wgt;
    logic signed [ACC_BITS-1:0] r_acc;
    t_sample r_out;
    logic    r_out_vld;

    t_slot   raddr;
    logic    entry_ok;
    logic [SAMPLE_BITS-1:0] rdata;
    t_sample sel;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0]  rnd;
    logic signed [ACC_BITS-1:0]  shifted;

    // oldest sample sits at the slot the next write will use
    assign raddr    = (i_cmd.load ? r_slot + 1'b1 : r_slot) + i_cmd.age;
    // entries not yet written hold the first sample
    assign entry_ok = r_full || (raddr < r_slot);

    twa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_slot),
        .i_wdata (i_sample),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign sel     = r_use_ram ? t_sample'(rdata) : r_prime_val;
    assign prod    = sel * $signed({1'b0, r_wgt});
    assign rnd     = r_acc + ACC_BITS'(ROUND_HALF);
    assign shifted = rnd >>> SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_full    <= 1'b0;
            r_primed  <= 1'b0;
            r_mac     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_mac <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_slot   <= r_slot + 1'b1;
                r_primed <= 1'b1;
                if (r_slot == SLOT_BITS'(TAPS - 1)) begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !r_primed) begin
            r_prime_val <= i_sample;
        end
        r_use_ram <= entry_ok;
        r_wgt     <= tap_weight(i_cmd.age);
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_mac) begin
            r_acc <= r_acc + ACC_BITS'(prod);
        end
        if (i_cmd.out_load) begin
            r_out <= shifted[SAMPLE_BITS-1:0];
        end
    end

    assign o_sts.out_free = !r_out_vld || !i_stall;
    assign o_valid        = r_out_vld;
    assign o_smoothed     = r_out;

endmodule

@@ rtl/triangular_window_average.sv @@
// top level of the triangular-weighted moving average
//
// input channel: i_valid / i_sample, with o_stall driven back. a transfer
// happens on a rising edge with i_valid high and o_stall low.
// output channel: o_valid / o_smoothed, with i_stall from the receiver.
// every input transfer gives exactly one output transfer.
// each item takes one ram read per tap over 32 taps through a single
// multiply-accumulate, then a drain of the last product, then rounding into
// the output register. o_stall stays high after each input transfer until
// the result is loaded into the output register, so no new sample is taken
// before the last one is done.
// the result sits in its own register, so a new sample may transfer while a
// finished result is still held by a stalled receiver; if the next result is
// done before that one leaves, the block waits with o_stall high.
// a synchronous low i_rst_n empties the output register and rewinds the ring.
// the first sample after reset stands in for every ring entry not yet written.
module triangular_window_average (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  twa_pkg::t_sample i_sample,
    output logic             o_stall,
    output logic             o_valid,
    output twa_pkg::t_sample o_smoothed,
    input  logic             i_stall
);
    import twa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    twa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    twa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_sample   (i_sample),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_smoothed (o_smoothed)
    );

endmodule

@@ rtl/twa_chk.sv @@
// port-level assertions for the triangular window average
module twa_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input twa_pkg::t_sample o_smoothed,
    input logic             i_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_smoothed))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after a transfer");

    a_busy_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> ##32 o_stall)
        else $error("item finished too early");

    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result shown while still busy");

endmodule

bind triangular_window_average twa_chk u_twa_chk (.*);
